>>> rtl/wkm_pkg.sv
// ---------------------------------------------------------------------------
// wkm_pkg: shared types and constants for weighted k-means clustering
// Item codes, register indexes, controller states and the command and
// status groups that join the controller and the datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wkm_pkg;

  // item function codes
  localparam logic [1:0] FN_LOAD_PART = 2'd0;
  localparam logic [1:0] FN_LOAD_CTR  = 2'd1;
  localparam logic [1:0] FN_RUN       = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_PARTICLE_COUNT  = 2'd0;
  localparam logic [1:0] CFG_CENTER_COUNT    = 2'd1;
  localparam logic [1:0] CFG_ITERATION_LIMIT = 2'd2;

  localparam logic [10:0] PARTICLE_COUNT_RST  = 11'd1000;
  localparam logic [3:0]  CENTER_COUNT_RST    = 4'd1;
  localparam logic [7:0]  ITERATION_LIMIT_RST = 8'd10;

  // 1e-3 m squared in Q32.32, rounded down
  localparam logic [65:0] SHIFT_SQ_MAX = 66'd4294;

  localparam int DIV_STEPS = 64;

  typedef enum logic [4:0] {
    S_IDLE, S_ITER_START, S_PRD, S_DINIT, S_DDIF, S_DMUL, S_DACC, S_DCMP,
    S_WMUL, S_WACC, S_UPD_START, S_UCHK, S_DIVGO, S_DIVW, S_SINIT, S_SCMP,
    S_ITER_END, S_EMIT
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP, DP_LOAD_PART, DP_LOAD_CTR, DP_READ_PART, DP_CLR_SUMS, DP_DIST_CLR,
    DP_DIFF, DP_MUL_DIST, DP_ACC_DIST, DP_BEST, DP_MUL_W, DP_SUM_ADD,
    DP_NEW_ZERO, DP_DIV_START, DP_DIV_STORE, DP_COMMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] axis;
    logic       half;        // upper 16 bits of the magnitude
    logic       shift_mode;  // old center against new center
    logic       first;       // first center of a particle
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic wsum_zero;
    logic shift_big;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/wkm_chan_if.sv
// ---------------------------------------------------------------------------
// wkm channel interfaces
// Input item, result item and register write channels, valid/ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface wkm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [9:0]         slot;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  logic [15:0]        weight;
  modport source (output valid, func, slot, coord_x, coord_y, coord_z, weight,
                  input ready);
  modport sink (input valid, func, slot, coord_x, coord_y, coord_z, weight,
                output ready);
endinterface

interface wkm_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         center_slot;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic [7:0]         iterations_done;
  logic               converged;
  logic               last;
  modport source (output valid, center_slot, center_x, center_y, center_z,
                  iterations_done, converged, last, input ready);
  modport sink (input valid, center_slot, center_x, center_y, center_z,
                iterations_done, converged, last, output ready);
endinterface

interface wkm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  idx;
  logic [15:0] data;
  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

`default_nettype wire

>>> rtl/wkm_div.sv
// ---------------------------------------------------------------------------
// wkm_div: restoring divider
// 64-bit by 32-bit unsigned, one quotient bit per cycle, done pulse at end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wkm_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [63:0]      quotient
);
  import wkm_pkg::*;

  logic [63:0] q_r, q_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] d_r, d_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] sh;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh       = {rem_r, q_r[63]};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
      cnt_nxt  = 7'(DIV_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, d_r}) begin
        rem_nxt = 32'(sh - {1'b0, d_r});
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = sh[31:0];
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

`default_nettype wire

>>> rtl/wkm_dp.sv
// ---------------------------------------------------------------------------
// wkm_dp: clustering datapath
// Particle memory, centers, cluster sums, shared multiplier, distance
// accumulator and the center averaging divider.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wkm_dp #(
  parameter int MAX_PARTICLES = 1024,
  parameter int MAX_CENTERS   = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire wkm_pkg::dp_cmd_t     cmd,
  input  wire logic [$clog2(MAX_PARTICLES)-1:0] pidx,
  input  wire logic [(MAX_CENTERS > 1 ? $clog2(MAX_CENTERS) : 1)-1:0] cidx,
  input  wire logic [9:0]           in_slot,
  input  wire logic signed [31:0]   in_x,
  input  wire logic signed [31:0]   in_y,
  input  wire logic signed [31:0]   in_z,
  input  wire logic [15:0]          in_w,
  output wkm_pkg::dp_stat_t         stat,
  output logic signed [31:0]        ctr_x,
  output logic signed [31:0]        ctr_y,
  output logic signed [31:0]        ctr_z
);
  import wkm_pkg::*;

  localparam int PW = $clog2(MAX_PARTICLES);
  localparam int CW = MAX_CENTERS > 1 ? $clog2(MAX_CENTERS) : 1;

  function automatic logic [31:0] pick3(input logic [1:0] ax, input logic [31:0] a,
                                        input logic [31:0] b, input logic [31:0] c);
    logic [31:0] r;
    unique case (ax)
      2'd0:    r = a;
      2'd1:    r = b;
      default: r = c;
    endcase
    return r;
  endfunction

  // particle memory: x, y, z, weight
  logic [111:0] pmem [MAX_PARTICLES];
  logic [111:0] prd_r;

  logic signed [31:0] cx_r [MAX_CENTERS];
  logic signed [31:0] cy_r [MAX_CENTERS];
  logic signed [31:0] cz_r [MAX_CENTERS];
  logic [63:0]        sum_r [MAX_CENTERS][3];
  logic [31:0]        sumw_r [MAX_CENTERS];
  logic [31:0]        new_r [3];

  logic [31:0]        mag_r;
  logic signed [49:0] prod_r;
  logic [65:0]        acc_r;
  logic [65:0]        best_acc_r;
  logic [CW-1:0]      best_r;
  logic               neg_r;

  logic [31:0]        px, py, pz;
  logic [15:0]        pw;
  logic [31:0]        op_a, op_b;
  logic signed [32:0] diff;
  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic [1:0]         sum_sel;
  logic [63:0]        num;
  logic [31:0]        wsum;
  logic [31:0]        half_w;
  logic [63:0]        dividend;
  logic               div_done;
  logic [63:0]        quot;
  logic [31:0]        qsat;
  logic [16:0]        slot_ext;

  assign px = prd_r[111:80];
  assign py = prd_r[79:48];
  assign pz = prd_r[47:16];
  assign pw = prd_r[15:0];

  assign slot_ext = {7'd0, in_slot};

  always_ff @(posedge clk) begin
    if (cmd.op == DP_LOAD_PART && 32'(slot_ext) < 32'(MAX_PARTICLES)) begin
      pmem[slot_ext[PW-1:0]] <= {in_x, in_y, in_z, in_w};
    end
    if (cmd.op == DP_READ_PART) begin
      prd_r <= pmem[pidx];
    end
  end

  // difference operands
  always_comb begin
    if (cmd.shift_mode) begin
      op_a = pick3(cmd.axis, cx_r[cidx], cy_r[cidx], cz_r[cidx]);
      op_b = pick3(cmd.axis, new_r[0], new_r[1], new_r[2]);
    end else begin
      op_a = pick3(cmd.axis, px, py, pz);
      op_b = pick3(cmd.axis, cx_r[cidx], cy_r[cidx], cz_r[cidx]);
    end
    diff = $signed({op_a[31], op_a}) - $signed({op_b[31], op_b});
  end

  // shared multiplier operands
  always_comb begin
    if (cmd.op == DP_MUL_W) begin
      mul_a = $signed({op_a[31], op_a});
      mul_b = $signed({1'b0, pw});
    end else begin
      mul_a = $signed({1'b0, mag_r});
      mul_b = cmd.half ? $signed({1'b0, mag_r[31:16]}) : $signed({1'b0, mag_r[15:0]});
    end
  end

  // averaging: rounded magnitude of sum / weight
  assign sum_sel  = (cmd.axis == 2'd0) ? 2'd0 : ((cmd.axis == 2'd1) ? 2'd1 : 2'd2);
  assign num      = sum_r[cidx][sum_sel];
  assign wsum     = sumw_r[cidx];
  assign half_w   = wsum >> 1;
  assign dividend = num[63] ? (~num + 64'(half_w) + 64'd1) : (num + 64'(half_w));

  wkm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == DP_DIV_START),
    .dividend (dividend),
    .divisor  (wsum),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    if (neg_r) begin
      qsat = (quot > 64'h8000_0000) ? 32'h8000_0000 : quot[31:0];
      qsat = 32'd0 - qsat;
    end else begin
      qsat = (quot > 64'h7fff_ffff) ? 32'h7fff_ffff : quot[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < MAX_CENTERS; c++) begin
        cx_r[c] <= '0;
        cy_r[c] <= '0;
        cz_r[c] <= '0;
      end
    end else begin
      if (cmd.op == DP_LOAD_CTR && 32'(slot_ext) < 32'(MAX_CENTERS)) begin
        cx_r[slot_ext[CW-1:0]] <= in_x;
        cy_r[slot_ext[CW-1:0]] <= in_y;
        cz_r[slot_ext[CW-1:0]] <= in_z;
      end
      if (cmd.op == DP_COMMIT) begin
        cx_r[cidx] <= new_r[0];
        cy_r[cidx] <= new_r[1];
        cz_r[cidx] <= new_r[2];
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_CLR_SUMS: begin
        for (int c = 0; c < MAX_CENTERS; c++) begin
          sumw_r[c] <= '0;
          for (int a = 0; a < 3; a++) begin
            sum_r[c][a] <= '0;
          end
        end
      end
      DP_DIST_CLR: acc_r <= '0;
      DP_DIFF:     mag_r <= diff[32] ? 32'(-diff) : 32'(diff);
      DP_MUL_DIST, DP_MUL_W: prod_r <= mul_a * mul_b;
      DP_ACC_DIST: begin
        if (cmd.half) begin
          acc_r <= acc_r + {2'd0, prod_r[47:0], 16'd0};
        end else begin
          acc_r <= acc_r + {18'd0, prod_r[47:0]};
        end
      end
      DP_BEST: begin
        if (cmd.first || acc_r < best_acc_r) begin
          best_acc_r <= acc_r;
          best_r     <= cidx;
        end
      end
      DP_SUM_ADD: begin
        unique case (cmd.axis)
          2'd0:    sum_r[best_r][0] <= sum_r[best_r][0] + 64'(prod_r);
          2'd1:    sum_r[best_r][1] <= sum_r[best_r][1] + 64'(prod_r);
          default: begin
            sum_r[best_r][2] <= sum_r[best_r][2] + 64'(prod_r);
            sumw_r[best_r]   <= sumw_r[best_r] + 32'(pw);
          end
        endcase
      end
      DP_NEW_ZERO: begin
        new_r[0] <= '0;
        new_r[1] <= '0;
        new_r[2] <= '0;
      end
      DP_DIV_START: neg_r <= num[63];
      DP_DIV_STORE: begin
        unique case (cmd.axis)
          2'd0:    new_r[0] <= qsat;
          2'd1:    new_r[1] <= qsat;
          default: new_r[2] <= qsat;
        endcase
      end
      default: ;
    endcase
  end

  assign stat.div_done  = div_done;
  assign stat.wsum_zero = (wsum == 32'd0);
  assign stat.shift_big = (acc_r > SHIFT_SQ_MAX);

  assign ctr_x = cx_r[cidx];
  assign ctr_y = cy_r[cidx];
  assign ctr_z = cz_r[cidx];

endmodule

`default_nettype wire

>>> rtl/wkm_ctrl.sv
// ---------------------------------------------------------------------------
// wkm_ctrl: clustering controller
// Register file, run sequencing over iterations, particles, centers and
// axes, and the result handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wkm_ctrl #(
  parameter int MAX_PARTICLES = 1024,
  parameter int MAX_CENTERS   = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_func,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_idx,
  input  wire logic [15:0]       cfg_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             out_center_slot,
  output logic [7:0]             out_iterations_done,
  output logic                   out_converged,
  output logic                   out_last,
  output wkm_pkg::dp_cmd_t       cmd,
  output logic [$clog2(MAX_PARTICLES)-1:0] pidx,
  output logic [(MAX_CENTERS > 1 ? $clog2(MAX_CENTERS) : 1)-1:0] cidx,
  input  wire wkm_pkg::dp_stat_t stat
);
  import wkm_pkg::*;

  localparam int PW  = $clog2(MAX_PARTICLES);
  localparam int PCW = $clog2(MAX_PARTICLES + 1);
  localparam int CW  = MAX_CENTERS > 1 ? $clog2(MAX_CENTERS) : 1;
  localparam int KCW = $clog2(MAX_CENTERS + 1);

  state_t         state_r, state_nxt;
  logic [10:0]    pc_r;
  logic [3:0]     cc_r;
  logic [7:0]     il_r;
  logic [PCW-1:0] np_r, np_nxt;
  logic [KCW-1:0] k_r, k_nxt;
  logic [7:0]     lim_r, lim_nxt;
  logic [7:0]     it_r, it_nxt;
  logic [PCW-1:0] p_r, p_nxt;
  logic [KCW-1:0] j_r, j_nxt;
  logic [1:0]     axis_r, axis_nxt;
  logic           half_r, half_nxt;
  logic           mode_r, mode_nxt;
  logic           conv_r, conv_nxt;
  logic           j_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PARTICLE_COUNT_RST;
      cc_r <= CENTER_COUNT_RST;
      il_r <= ITERATION_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx)
        CFG_PARTICLE_COUNT:  pc_r <= cfg_data[10:0];
        CFG_CENTER_COUNT:    cc_r <= cfg_data[3:0];
        CFG_ITERATION_LIMIT: il_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      np_r    <= '0;
      k_r     <= '0;
      lim_r   <= '0;
      it_r    <= '0;
      p_r     <= '0;
      j_r     <= '0;
      axis_r  <= '0;
      half_r  <= 1'b0;
      mode_r  <= 1'b0;
      conv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      np_r    <= np_nxt;
      k_r     <= k_nxt;
      lim_r   <= lim_nxt;
      it_r    <= it_nxt;
      p_r     <= p_nxt;
      j_r     <= j_nxt;
      axis_r  <= axis_nxt;
      half_r  <= half_nxt;
      mode_r  <= mode_nxt;
      conv_r  <= conv_nxt;
    end
  end

  assign j_last = (KCW'(j_r + 1'b1) == k_r);

  always_comb begin
    state_nxt  = state_r;
    np_nxt     = np_r;
    k_nxt      = k_r;
    lim_nxt    = lim_r;
    it_nxt     = it_r;
    p_nxt      = p_r;
    j_nxt      = j_r;
    axis_nxt   = axis_r;
    half_nxt   = half_r;
    mode_nxt   = mode_r;
    conv_nxt   = conv_r;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd.op     = DP_NOP;
    cmd.axis   = axis_r;
    cmd.half   = half_r;
    cmd.shift_mode = mode_r;
    cmd.first  = (j_r == '0);

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_func)
            FN_LOAD_PART: cmd.op = DP_LOAD_PART;
            FN_LOAD_CTR:  cmd.op = DP_LOAD_CTR;
            FN_RUN: begin
              np_nxt  = (32'(pc_r) > 32'(MAX_PARTICLES)) ? PCW'(MAX_PARTICLES)
                                                         : PCW'(pc_r);
              if (cc_r == 4'd0) begin
                k_nxt = KCW'(1);
              end else if (32'(cc_r) > 32'(MAX_CENTERS)) begin
                k_nxt = KCW'(MAX_CENTERS);
              end else begin
                k_nxt = KCW'(cc_r);
              end
              lim_nxt   = (il_r == 8'd0) ? 8'd1 : il_r;
              it_nxt    = '0;
              state_nxt = S_ITER_START;
            end
            default: ;
          endcase
        end
      end
      S_ITER_START: begin
        cmd.op    = DP_CLR_SUMS;
        it_nxt    = it_r + 8'd1;
        p_nxt     = '0;
        state_nxt = (np_r == '0) ? S_UPD_START : S_PRD;
      end
      S_PRD: begin
        cmd.op    = DP_READ_PART;
        j_nxt     = '0;
        mode_nxt  = 1'b0;
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd.op    = DP_DIST_CLR;
        axis_nxt  = '0;
        half_nxt  = 1'b0;
        state_nxt = S_DDIF;
      end
      S_DDIF: begin
        cmd.op    = DP_DIFF;
        state_nxt = S_DMUL;
      end
      S_DMUL: begin
        cmd.op    = DP_MUL_DIST;
        state_nxt = S_DACC;
      end
      S_DACC: begin
        cmd.op = DP_ACC_DIST;
        if (!half_r) begin
          half_nxt  = 1'b1;
          state_nxt = S_DMUL;
        end else begin
          half_nxt = 1'b0;
          if (axis_r == 2'd2) begin
            state_nxt = mode_r ? S_SCMP : S_DCMP;
          end else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = S_DDIF;
          end
        end
      end
      S_DCMP: begin
        cmd.op = DP_BEST;
        if (j_last) begin
          axis_nxt  = '0;
          state_nxt = S_WMUL;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_DINIT;
        end
      end
      S_WMUL: begin
        cmd.op    = DP_MUL_W;
        state_nxt = S_WACC;
      end
      S_WACC: begin
        cmd.op = DP_SUM_ADD;
        if (axis_r == 2'd2) begin
          axis_nxt = '0;
          if (PCW'(p_r + 1'b1) == np_r) begin
            state_nxt = S_UPD_START;
          end else begin
            p_nxt     = p_r + 1'b1;
            state_nxt = S_PRD;
          end
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_WMUL;
        end
      end
      S_UPD_START: begin
        j_nxt     = '0;
        conv_nxt  = 1'b1;
        state_nxt = S_UCHK;
      end
      S_UCHK: begin
        axis_nxt = '0;
        if (stat.wsum_zero) begin
          cmd.op    = DP_NEW_ZERO;
          state_nxt = S_SINIT;
        end else begin
          state_nxt = S_DIVGO;
        end
      end
      S_DIVGO: begin
        cmd.op    = DP_DIV_START;
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (stat.div_done) begin
          cmd.op = DP_DIV_STORE;
          if (axis_r == 2'd2) begin
            state_nxt = S_SINIT;
          end else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = S_DIVGO;
          end
        end
      end
      S_SINIT: begin
        cmd.op    = DP_DIST_CLR;
        mode_nxt  = 1'b1;
        axis_nxt  = '0;
        half_nxt  = 1'b0;
        state_nxt = S_DDIF;
      end
      S_SCMP: begin
        cmd.op   = DP_COMMIT;
        mode_nxt = 1'b0;
        if (stat.shift_big) begin
          conv_nxt = 1'b0;
        end
        if (j_last) begin
          state_nxt = S_ITER_END;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_UCHK;
        end
      end
      S_ITER_END: begin
        if (conv_r || it_r == lim_r) begin
          j_nxt     = '0;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_ITER_START;
        end
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (j_last) begin
            state_nxt = S_IDLE;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign pidx                = p_r[PW-1:0];
  assign cidx                = j_r[CW-1:0];
  assign out_center_slot     = 3'(j_r);
  assign out_iterations_done = it_r;
  assign out_converged       = conv_r;
  assign out_last            = j_last;

endmodule

`default_nettype wire

>>> rtl/weighted_kmeans_clustering_top.sv
// Load items (particle or center) and run items are accepted only while idle; a run
//   then works through up to L iterations, L = iterations done, over NP = particles and
//   K = centers; a center update runs the 64-step divider three times, an empty
//   cluster skips it. One item at a time.
// Results follow as K items, one per cycle while out ready is high.
// Synchronous active-low reset clears centers and control and sets registers to defaults.
// ---------------------------------------------------------------------------
// weighted_kmeans_clustering_top: weighted k-means clustering engine
// Stores particles and centers, runs Lloyd iterations, emits centers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module weighted_kmeans_clustering_top #(
  parameter int MAX_PARTICLES = 1024,
  parameter int MAX_CENTERS   = 8
) (
  input wire logic   clk,
  input wire logic   rst_n,
  wkm_in_if.sink     in_ch,
  wkm_out_if.source  out_ch,
  wkm_cfg_if.sink    cfg_ch
);
  import wkm_pkg::*;

  localparam int PW = $clog2(MAX_PARTICLES);
  localparam int CW = MAX_CENTERS > 1 ? $clog2(MAX_CENTERS) : 1;

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  logic [PW-1:0] pidx;
  logic [CW-1:0] cidx;
  logic          in_ready;
  logic          cfg_ready;
  logic          out_valid;
  logic [2:0]    center_slot;
  logic [7:0]    iterations_done;
  logic          converged;
  logic          last;
  logic signed [31:0] ctr_x, ctr_y, ctr_z;

  wkm_ctrl #(
    .MAX_PARTICLES (MAX_PARTICLES),
    .MAX_CENTERS   (MAX_CENTERS)
  ) u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_ch.valid),
    .in_ready            (in_ready),
    .in_func             (in_ch.func),
    .cfg_valid           (cfg_ch.valid),
    .cfg_ready           (cfg_ready),
    .cfg_idx             (cfg_ch.idx),
    .cfg_data            (cfg_ch.data),
    .out_valid           (out_valid),
    .out_ready           (out_ch.ready),
    .out_center_slot     (center_slot),
    .out_iterations_done (iterations_done),
    .out_converged       (converged),
    .out_last            (last),
    .cmd                 (cmd),
    .pidx                (pidx),
    .cidx                (cidx),
    .stat                (stat)
  );

  wkm_dp #(
    .MAX_PARTICLES (MAX_PARTICLES),
    .MAX_CENTERS   (MAX_CENTERS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .pidx    (pidx),
    .cidx    (cidx),
    .in_slot (in_ch.slot),
    .in_x    (in_ch.coord_x),
    .in_y    (in_ch.coord_y),
    .in_z    (in_ch.coord_z),
    .in_w    (in_ch.weight),
    .stat    (stat),
    .ctr_x   (ctr_x),
    .ctr_y   (ctr_y),
    .ctr_z   (ctr_z)
  );

  assign in_ch.ready            = in_ready;
  assign cfg_ch.ready           = cfg_ready;
  assign out_ch.valid           = out_valid;
  assign out_ch.center_slot     = center_slot;
  assign out_ch.center_x        = ctr_x;
  assign out_ch.center_y        = ctr_y;
  assign out_ch.center_z        = ctr_z;
  assign out_ch.iterations_done = iterations_done;
  assign out_ch.converged       = converged;
  assign out_ch.last            = last;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_run_not_instant: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ready && in_ch.func == FN_RUN) |=> !out_valid)
    else $error("result appeared right after run item");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ch.ready && last) |=> (!out_valid && in_ready))
    else $error("block not idle after final center");

endmodule

`default_nettype wire

>>> tb/sv/tb_weighted_kmeans_clustering_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_weighted_kmeans_clustering_top: weighted k-means engine testbench
// Loads particles and centers, runs clustering under several register
// settings and checks every emitted center against a local fixed-point
// model of the Lloyd iterations.
// ---------------------------------------------------------------------------
module tb_weighted_kmeans_clustering_top;
  import wkm_pkg::*;

  localparam int CYCLE_LIMIT = 30_000_000;

  typedef struct {
    logic [2:0]  slot;
    logic [31:0] x, y, z;
    logic [7:0]  iters;
    logic        conv;
    logic        last;
  } center_t;

  class CenterPredictor;
    logic [31:0] px[1024], py[1024], pz[1024];
    logic [15:0] pw[1024];
    logic [31:0] cx[8], cy[8], cz[8];
    int unsigned npart, nctr, nlim;
    center_t     exp_centers[$];
    int          errors;

    function new();
      for (int i = 0; i < 8; i++) begin
        cx[i] = 0; cy[i] = 0; cz[i] = 0;
      end
      npart = PARTICLE_COUNT_RST; nctr = CENTER_COUNT_RST; nlim = ITERATION_LIMIT_RST;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_PARTICLE_COUNT:  npart = val[10:0];
        CFG_CENTER_COUNT:    nctr = val[3:0];
        CFG_ITERATION_LIMIT: nlim = val[7:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] sq_diff(logic [31:0] a, logic [31:0] b);
      longint d;
      d = longint'(signed'(a)) - longint'(signed'(b));
      if (d < 0) d = -d;
      return d * d;
    endfunction

    function logic [65:0] dist2(logic [31:0] ax, ay, az, bx, by, bz);
      return {2'b0, sq_diff(ax, bx)} + {2'b0, sq_diff(ay, by)} + {2'b0, sq_diff(az, bz)};
    endfunction

    function logic [31:0] wavg(longint num, logic [31:0] w);
      logic [63:0] mag, q;
      mag = (num < 0) ? -num : num;
      q = (mag + {33'd0, w[31:1]}) / {32'd0, w};
      if (num < 0) begin
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        return -q[31:0];
      end
      if (q > 64'h7fff_ffff) q = 64'h7fff_ffff;
      return q[31:0];
    endfunction

    function void note_item(logic [1:0] fn, logic [9:0] slot,
                            logic [31:0] x, y, z, logic [15:0] w);
      int unsigned np, k, lim, it, best;
      logic [65:0] bd, d;
      longint sx[8], sy[8], sz[8];
      logic [31:0] sw[8], nx, ny, nz;
      logic [2:0] cl[1024];
      bit conv, done;
      center_t c;
      if (fn == FN_LOAD_PART) begin
        px[slot] = x; py[slot] = y; pz[slot] = z; pw[slot] = w;
        return;
      end
      if (fn == FN_LOAD_CTR) begin
        if (slot < 8) begin
          cx[slot] = x; cy[slot] = y; cz[slot] = z;
        end
        return;
      end
      if (fn != FN_RUN) return;
      np = (npart > 1024) ? 1024 : npart;
      k = (nctr == 0) ? 1 : ((nctr > 8) ? 8 : nctr);
      lim = (nlim == 0) ? 1 : nlim;
      conv = 0; done = 0; it = 0;
      while (!done) begin
        it++;
        for (int i = 0; i < np; i++) begin
          best = 0;
          bd = dist2(px[i], py[i], pz[i], cx[0], cy[0], cz[0]);
          for (int j = 1; j < k; j++) begin
            d = dist2(px[i], py[i], pz[i], cx[j], cy[j], cz[j]);
            if (d < bd) begin
              bd = d; best = j;
            end
          end
          cl[i] = 3'(best);
        end
        for (int j = 0; j < 8; j++) begin
          sx[j] = 0; sy[j] = 0; sz[j] = 0; sw[j] = 0;
        end
        for (int i = 0; i < np; i++) begin
          sx[cl[i]] += longint'(signed'(px[i])) * longint'(pw[i]);
          sy[cl[i]] += longint'(signed'(py[i])) * longint'(pw[i]);
          sz[cl[i]] += longint'(signed'(pz[i])) * longint'(pw[i]);
          sw[cl[i]] += pw[i];
        end
        conv = 1;
        for (int j = 0; j < k; j++) begin
          nx = 0; ny = 0; nz = 0;
          if (sw[j] != 0) begin
            nx = wavg(sx[j], sw[j]); ny = wavg(sy[j], sw[j]); nz = wavg(sz[j], sw[j]);
          end
          if (dist2(cx[j], cy[j], cz[j], nx, ny, nz) > SHIFT_SQ_MAX) conv = 0;
          cx[j] = nx; cy[j] = ny; cz[j] = nz;
        end
        if (conv || it >= lim) done = 1;
      end
      for (int a = 0; a < k; a++) begin
        c.slot = 3'(a); c.x = cx[a]; c.y = cy[a]; c.z = cz[a];
        c.iters = 8'(it); c.conv = conv; c.last = (a + 1 == k);
        exp_centers = {exp_centers, c};
      end
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
    endtask

    task check_center(center_t r);
      center_t e;
      if (exp_centers.size() == 0) begin
        report("unexpected center", 32'(r.slot), 32'd0);
        return;
      end
      e = exp_centers.pop_front();
      if (r.slot !== e.slot) report("center_slot", 32'(r.slot), 32'(e.slot));
      if (r.x !== e.x) report("center_x", r.x, e.x);
      if (r.y !== e.y) report("center_y", r.y, e.y);
      if (r.z !== e.z) report("center_z", r.z, e.z);
      if (r.iters !== e.iters) report("iterations_done", 32'(r.iters), 32'(e.iters));
      if (r.conv !== e.conv) report("converged", 32'(r.conv), 32'(e.conv));
      if (r.last !== e.last) report("last", 32'(r.last), 32'(e.last));
    endtask
  endclass

  logic clk;
  logic rst_n;
  wkm_in_if  in_ch();
  wkm_out_if out_ch();
  wkm_cfg_if cfg_ch();

  weighted_kmeans_clustering_top u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  CenterPredictor pred = new();
  int unsigned cycles = 0;
  int unsigned items_sent = 0, runs_sent = 0, centers_seen = 0;
  int unsigned burst_left = 0;
  bit hold_req = 0;
  bit hold_done = 0;
  int unsigned hold_cnt = 0;
  bit stall_mode = 0;
  logic [31:0] blob[4];

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // receiver: random stall pattern plus one long hold-off once results show up
  initial begin
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_req && out_ch.valid) begin
        hold_cnt = 3000; hold_req = 0;
      end
      if ($urandom_range(0, 199) == 0) stall_mode = ~stall_mode;
      if (hold_cnt > 0) begin
        hold_cnt--; out_ch.ready = 0;
      end else if (stall_mode) begin
        out_ch.ready = ($urandom_range(0, 3) == 0);
      end else begin
        out_ch.ready = 1;
      end
    end
  end

  always @(posedge clk) begin
    center_t r;
    cycles++;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      r.slot = out_ch.center_slot; r.x = out_ch.center_x; r.y = out_ch.center_y;
      r.z = out_ch.center_z; r.iters = out_ch.iterations_done;
      r.conv = out_ch.converged; r.last = out_ch.last;
      centers_seen++;
      pred.check_center(r);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[weighted_kmeans_clustering_top] ERROR");
      $finish;
    end
  end

  task send_item(logic [1:0] fn, logic [9:0] slot, logic [31:0] x, y, z, logic [15:0] w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid = 0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid = 1; in_ch.func = fn; in_ch.slot = slot;
    in_ch.coord_x = x; in_ch.coord_y = y; in_ch.coord_z = z; in_ch.weight = w;
    do @(posedge clk); while (!in_ch.ready);
    pred.note_item(fn, slot, x, y, z, w);
    items_sent++;
    if (fn == FN_RUN) runs_sent++;
  endtask

  task wait_idle();
    @(negedge clk);
    in_ch.valid = 0;
    burst_left = 0;
    while (pred.exp_centers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_ch.valid = 1; cfg_ch.idx = idx; cfg_ch.data = val;
    do @(posedge clk); while (!cfg_ch.ready);
    pred.set_reg(idx, val);
    @(negedge clk);
    cfg_ch.valid = 0;
  endtask

  task set_regs(logic [15:0] np, logic [15:0] k, logic [15:0] lim);
    wait_idle();
    write_reg(CFG_PARTICLE_COUNT, np);
    write_reg(CFG_CENTER_COUNT, k);
    write_reg(CFG_ITERATION_LIMIT, lim);
  endtask

  function logic [31:0] near_blob();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return blob[$urandom_range(0, 3)] + $urandom_range(0, 32'h3_ffff) - 32'h2_0000;
    endcase
  endfunction

  function logic [15:0] rand_weight();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task load_particle(int i);
    send_item(FN_LOAD_PART, 10'(i), near_blob(), near_blob(), near_blob(), rand_weight());
  endtask

  task load_center(int j);
    send_item(FN_LOAD_CTR, 10'(j), near_blob(), near_blob(), near_blob(), 16'($urandom));
  endtask

  initial begin
    int unsigned np, k, lim, nruns;
    in_ch.valid = 0; in_ch.func = FN_LOAD_PART; in_ch.slot = 0;
    in_ch.coord_x = 0; in_ch.coord_y = 0; in_ch.coord_z = 0; in_ch.weight = 0;
    cfg_ch.valid = 0; cfg_ch.idx = CFG_PARTICLE_COUNT; cfg_ch.data = 0;
    for (int b = 0; b < 4; b++) blob[b] = $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
    rst_n = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: extremes, ties, empty cluster, ignored slots and codes
    set_regs(2, 2, 1);
    send_item(FN_LOAD_PART, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 16'hffff);
    send_item(FN_LOAD_PART, 1, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'h0000);
    send_item(FN_LOAD_CTR, 0, 32'h0, 32'h0, 32'h0, 16'h0);
    send_item(FN_LOAD_CTR, 1, 32'h0, 32'h0, 32'h0, 16'hffff);  // tie with center 0
    send_item(FN_LOAD_CTR, 8, 32'h1234, 32'h1234, 32'h1234, 0);  // out of range, ignored
    send_item(FN_LOAD_CTR, 10'h3ff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0);
    send_item(2'd3, 10'h3ff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 16'hffff);
    send_item(FN_RUN, 0, 0, 0, 0, 0);
    send_item(FN_LOAD_PART, 1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 16'h8000);
    send_item(FN_LOAD_CTR, 1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    send_item(FN_RUN, 0, 0, 0, 0, 0);
    set_regs(0, 0, 0);  // no particles, centers to origin
    send_item(FN_RUN, 0, 0, 0, 0, 0);
    set_regs(2, 15, 255);
    for (int j = 0; j < 8; j++) load_center(j);
    send_item(FN_RUN, 0, 0, 0, 0, 0);

    // larger particle set, plus a write to the top memory slot
    set_regs(96, 3, 4);
    for (int i = 0; i < 96; i++) load_particle(i);
    load_particle(1023);
    for (int j = 0; j < 3; j++) load_center(j);
    send_item(FN_RUN, 0, 0, 0, 0, 0);

    // random phases
    while (items_sent < 480) begin
      np = $urandom_range(1, 12);
      k = $urandom_range(0, 15);
      lim = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 12);
      if (lim > 12) np = $urandom_range(1, 3);
      set_regs(16'(np), 16'(k), 16'(lim));
      for (int i = 0; i < np; i++) load_particle(i);
      for (int j = 0; j < 8; j++) load_center(j);
      nruns = $urandom_range(1, 3);
      if (!hold_done && runs_sent >= 10) begin
        hold_req = 1; hold_done = 1; nruns = 3;
      end
      for (int r = 0; r < nruns; r++) begin
        repeat ($urandom_range(0, 3)) begin
          case ($urandom_range(0, 3))
            0: load_particle($urandom_range(0, np - 1));
            1: load_center($urandom_range(0, 7));
            2: send_item(FN_LOAD_CTR, 10'($urandom_range(8, 1023)), $urandom, $urandom,
                         $urandom, 16'($urandom));
            default: send_item(2'd3, 10'($urandom), $urandom, $urandom, $urandom,
                               16'($urandom));
          endcase
        end
        send_item(FN_RUN, 10'($urandom), $urandom, $urandom, $urandom, 16'($urandom));
      end
    end

    wait_idle();
    repeat (200) @(posedge clk);
    $display("covered %0d items, %0d runs, %0d centers checked", items_sent, runs_sent,
             centers_seen);
    $display("register settings from minimum to saturated, with a long output hold-off");
    if (pred.errors == 0 && pred.exp_centers.size() == 0) begin
      $display("[weighted_kmeans_clustering_top] OK");
    end else begin
      $display("%0d mismatches, %0d centers missing", pred.errors, pred.exp_centers.size());
      $display("[weighted_kmeans_clustering_top] ERROR");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/wkm_pkg.sv
rtl/wkm_chan_if.sv
rtl/wkm_div.sv
rtl/wkm_dp.sv
rtl/wkm_ctrl.sv
rtl/weighted_kmeans_clustering_top.sv
tb/sv/tb_weighted_kmeans_clustering_top.sv
